/* sv/dda_line_rasterizer_assert.svh */
// Assertion macros used by the checker file.
`ifndef DDA_LINE_RASTERIZER_ASSERT_SVH
`define DDA_LINE_RASTERIZER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dda line rasterizer check failed");

// The consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dda line rasterizer check failed");

`endif

/* sv/dda_lr_pkg.sv */
`timescale 1ns / 1ps

package dda_lr_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int RESET_START_X = 0;
    localparam int RESET_START_Y = -25;
    localparam int RESET_END_X   = 0;
    localparam int RESET_END_Y   = 10;

    typedef enum logic [1:0] {
        REG_START_X,
        REG_START_Y,
        REG_END_X,
        REG_END_Y
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MAGS,
        ST_DIVX_GO,
        ST_DIVX_RUN,
        ST_DIVY_GO,
        ST_DIVY_RUN,
        ST_STEP,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic start;
    } div_req_t;

    typedef struct packed {
        logic done;
    } div_stat_t;

endpackage

/* sv/dda_lr_div.sv */
`timescale 1ns / 1ps

module dda_lr_div #(
    parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_lr_pkg::FRAC_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  dda_lr_pkg::div_req_t   req,
    output dda_lr_pkg::div_stat_t  stat,
    input  logic [COORD_BITS-1:0]  dividend,
    input  logic [COORD_BITS-1:0]  divisor,
    output logic [FRAC_BITS:0]     quotient
);
    import dda_lr_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [COORD_BITS:0]   rem_reg;
    logic [COORD_BITS:0]   rem_next;
    logic [FRAC_BITS-1:0]  q_reg;
    logic [COORD_BITS-1:0] div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic                  busy_reg;
    logic [COORD_BITS:0]   trial;
    logic                  q_bit;
    logic                  last_iter;

    // One restoring step per cycle: compare, subtract, shift.
    always_comb
    begin
        trial     = rem_reg - {1'b0, div_reg};
        q_bit     = (rem_reg >= {1'b0, div_reg});
        rem_next  = q_bit ? trial : rem_reg;
        last_iter = busy_reg && (cnt_reg == CNT_W'(FRAC_BITS));
    end

    assign stat.done = last_iter;
    assign quotient  = {q_reg, q_bit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= !last_iter;
            cnt_reg  <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {1'b0, dividend};
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= {rem_next[COORD_BITS-1:0], 1'b0};
            q_reg   <= {q_reg[FRAC_BITS-2:0], q_bit};
        end
    end

endmodule

/* sv/dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// Restart tick (and first tick after reset): the result passes through setup, magnitudes and
// the shared restoring divider, which runs FRAC_BITS+1 steps per axis; a zero-length line
// skips the divider. Advancing tick: accumulator add, then rounding; a tick past the end
// goes straight to rounding.
// One tick in flight at a time; a new tick is taken while the previous result waits.
// Asynchronous active-low reset clears the sequencer and accumulators and reloads the
// reset endpoints.
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_lr_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  dda_lr_pkg::reg_index_t     cfg_index,
    input  logic [COORD_BITS-1:0]      cfg_data,
    input  logic                       tick_valid,
    output logic                       tick_stall,
    input  logic                       restart,
    output logic                       pixel_valid,
    input  logic                       pixel_stall,
    output logic [COORD_BITS-1:0]      pixel_x,
    output logic [COORD_BITS-1:0]      pixel_y,
    output logic                       is_last,
    output logic                       past_end
);
    import dda_lr_pkg::*;

    localparam int ACC_W  = COORD_BITS + FRAC_BITS + 1;
    localparam int STEP_W = FRAC_BITS + 2;
    localparam logic [ACC_W-1:0] HALF = {{(ACC_W - FRAC_BITS){1'b0}}, 1'b1,
                                         {(FRAC_BITS - 1){1'b0}}};

    state_t state_reg;
    state_t state_next;

    logic [COORD_BITS-1:0] start_x_reg;
    logic [COORD_BITS-1:0] start_y_reg;
    logic [COORD_BITS-1:0] end_x_reg;
    logic [COORD_BITS-1:0] end_y_reg;

    logic [ACC_W-1:0]      acc_x_reg;
    logic [ACC_W-1:0]      acc_y_reg;
    logic [STEP_W-1:0]     step_x_reg;
    logic [STEP_W-1:0]     step_y_reg;
    logic [COORD_BITS:0]   points_left_reg;
    logic                  line_started_reg;

    logic [COORD_BITS:0]   dx_reg;
    logic [COORD_BITS:0]   dy_reg;
    logic [COORD_BITS-1:0] mag_x_reg;
    logic [COORD_BITS-1:0] mag_y_reg;
    logic [COORD_BITS-1:0] steps_reg;
    logic                  last_reg;
    logic                  past_reg;

    logic                  out_valid_reg;
    logic [COORD_BITS-1:0] pixel_x_reg;
    logic [COORD_BITS-1:0] pixel_y_reg;
    logic                  is_last_reg;
    logic                  past_end_reg;

    logic                  tick_xfer;
    logic                  out_load;
    logic                  out_free;
    div_req_t              div_req;
    div_stat_t             div_stat;
    logic [COORD_BITS-1:0] div_dividend;
    logic [FRAC_BITS:0]    div_quot;
    logic [COORD_BITS:0]   mx_full;
    logic [COORD_BITS:0]   my_full;
    logic [STEP_W-1:0]     quot_ext;

    function automatic logic [COORD_BITS-1:0] round_acc(input logic [ACC_W-1:0] a);
        logic [ACC_W-1:0]      m;
        logic [ACC_W-1:0]      s;
        logic [COORD_BITS-1:0] r;
        m = a[ACC_W-1] ? (~a + 1'b1) : a;
        s = m + HALF;
        r = s[FRAC_BITS +: COORD_BITS];
        return a[ACC_W-1] ? (~r + 1'b1) : r;
    endfunction

    dda_lr_div #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (div_req),
        .stat    (div_stat),
        .dividend(div_dividend),
        .divisor (steps_reg),
        .quotient(div_quot)
    );

    assign out_free  = !out_valid_reg || !pixel_stall;
    assign tick_xfer = tick_valid && !tick_stall;

    always_comb
    begin
        mx_full      = dx_reg[COORD_BITS] ? (~dx_reg + 1'b1) : dx_reg;
        my_full      = dy_reg[COORD_BITS] ? (~dy_reg + 1'b1) : dy_reg;
        div_dividend = (state_reg == ST_DIVX_GO) ? mag_x_reg : mag_y_reg;
        quot_ext     = {1'b0, div_quot};
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_xfer)
                begin
                    if (restart || !line_started_reg)
                        state_next = ST_SETUP;
                    else if (points_left_reg != '0)
                        state_next = ST_STEP;
                    else
                        state_next = ST_ROUND;
                end
            end
            ST_SETUP:    state_next = ST_MAGS;
            ST_MAGS:
            begin
                if (mx_full == '0 && my_full == '0)
                    state_next = ST_ROUND;
                else
                    state_next = ST_DIVX_GO;
            end
            ST_DIVX_GO:  state_next = ST_DIVX_RUN;
            ST_DIVX_RUN: state_next = div_stat.done ? ST_DIVY_GO : ST_DIVX_RUN;
            ST_DIVY_GO:  state_next = ST_DIVY_RUN;
            ST_DIVY_RUN: state_next = div_stat.done ? ST_ROUND : ST_DIVY_RUN;
            ST_STEP:     state_next = ST_ROUND;
            ST_ROUND:    state_next = out_free ? ST_IDLE : ST_ROUND;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_stall    = (state_reg != ST_IDLE);
        div_req.start = (state_reg == ST_DIVX_GO) || (state_reg == ST_DIVY_GO);
        out_load      = (state_reg == ST_ROUND) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= COORD_BITS'(RESET_START_X);
            start_y_reg <= COORD_BITS'(RESET_START_Y);
            end_x_reg   <= COORD_BITS'(RESET_END_X);
            end_y_reg   <= COORD_BITS'(RESET_END_Y);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_START_X: start_x_reg <= cfg_data;
                REG_START_Y: start_y_reg <= cfg_data;
                REG_END_X:   end_x_reg   <= cfg_data;
                REG_END_Y:   end_y_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_x_reg        <= '0;
            acc_y_reg        <= '0;
            step_x_reg       <= '0;
            step_y_reg       <= '0;
            points_left_reg  <= '0;
            line_started_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_MAGS:
                begin
                    acc_x_reg        <= {start_x_reg[COORD_BITS-1], start_x_reg,
                                         {FRAC_BITS{1'b0}}};
                    acc_y_reg        <= {start_y_reg[COORD_BITS-1], start_y_reg,
                                         {FRAC_BITS{1'b0}}};
                    step_x_reg       <= '0;
                    step_y_reg       <= '0;
                    points_left_reg  <= (mx_full > my_full) ? mx_full : my_full;
                    line_started_reg <= 1'b1;
                end
                ST_DIVX_RUN:
                begin
                    if (div_stat.done)
                        step_x_reg <= dx_reg[COORD_BITS] ? (~quot_ext + 1'b1) : quot_ext;
                end
                ST_DIVY_RUN:
                begin
                    if (div_stat.done)
                        step_y_reg <= dy_reg[COORD_BITS] ? (~quot_ext + 1'b1) : quot_ext;
                end
                ST_STEP:
                begin
                    acc_x_reg       <= acc_x_reg
                                       + {{(ACC_W - STEP_W){step_x_reg[STEP_W-1]}}, step_x_reg};
                    acc_y_reg       <= acc_y_reg
                                       + {{(ACC_W - STEP_W){step_y_reg[STEP_W-1]}}, step_y_reg};
                    points_left_reg <= points_left_reg - 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                last_reg <= 1'b1;
                past_reg <= 1'b1;
            end
            ST_SETUP:
            begin
                dx_reg <= {end_x_reg[COORD_BITS-1], end_x_reg}
                          - {start_x_reg[COORD_BITS-1], start_x_reg};
                dy_reg <= {end_y_reg[COORD_BITS-1], end_y_reg}
                          - {start_y_reg[COORD_BITS-1], start_y_reg};
            end
            ST_MAGS:
            begin
                mag_x_reg <= mx_full[COORD_BITS-1:0];
                mag_y_reg <= my_full[COORD_BITS-1:0];
                steps_reg <= (mx_full > my_full) ? mx_full[COORD_BITS-1:0]
                                                 : my_full[COORD_BITS-1:0];
                last_reg  <= (mx_full == '0) && (my_full == '0);
                past_reg  <= 1'b0;
            end
            ST_STEP:
            begin
                last_reg <= (points_left_reg == (COORD_BITS + 1)'(1));
                past_reg <= 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!pixel_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_x_reg  <= round_acc(acc_x_reg);
            pixel_y_reg  <= round_acc(acc_y_reg);
            is_last_reg  <= last_reg;
            past_end_reg <= past_reg;
        end
    end

    assign pixel_valid = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign is_last     = is_last_reg;
    assign past_end    = past_end_reg;

endmodule

/* sv/dda_lr_checker.sv */
`timescale 1ns / 1ps
`include "dda_line_rasterizer_assert.svh"

module dda_lr_checker #(
    parameter int COORD_BITS = dda_lr_pkg::COORD_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  tick_valid,
    input logic                  tick_stall,
    input logic                  pixel_valid,
    input logic                  pixel_stall,
    input logic [COORD_BITS-1:0] pixel_x,
    input logic [COORD_BITS-1:0] pixel_y,
    input logic                  is_last,
    input logic                  past_end
);

    // A point past the end is always the held last point.
    `DDA_ASSERT_SAME(a_past_is_last, clk, rst_n, pixel_valid && past_end, is_last)

    // A transfer of a tick keeps the block busy in the following cycle.
    `DDA_ASSERT_NEXT(a_busy_after_tick, clk, rst_n, tick_valid && !tick_stall, tick_stall)

    // A new result only appears after the block has been working on a tick.
    `DDA_ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(pixel_valid), $past(tick_stall))

    // A stalled result holds.
    `DDA_ASSERT_NEXT(a_out_hold, clk, rst_n, pixel_valid && pixel_stall,
        pixel_valid && $stable(pixel_x) && $stable(pixel_y) && $stable(is_last))

endmodule

bind dda_line_rasterizer dda_lr_checker #(
    .COORD_BITS(COORD_BITS)
) u_dda_lr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .is_last    (is_last),
    .past_end   (past_end)
);
